// File: sv/dssms_pkg.sv
// package for the dual sensor safety mode selector
// holds transaction payload types, mode codes and the position cap helper
// no dependencies
package dssms_pkg;

   // mode codes
   localparam logic [1:0] MODE_NORMAL = 2'd0;
   localparam logic [1:0] MODE_S1_ONLY = 2'd1;
   localparam logic [1:0] MODE_S2_ONLY = 2'd2;
   localparam logic [1:0] MODE_FAIL = 2'd3;

   // fault flag bit positions
   localparam int FLAG_BOTH = 0;
   localparam int FLAG_S1 = 1;
   localparam int FLAG_S2 = 2;

   // configuration register indexes
   localparam logic [1:0] CSR_DEFAULT_POSITION = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_CLOSED_STOP = 2'd1;
   localparam logic [1:0] CSR_DEFAULT_OPEN_STOP = 2'd2;
   localparam logic [1:0] CSR_DEFAULT_LIMP_HOME = 2'd3;

   // saturation limits
   localparam logic [10:0] POS_CAP = 11'd1024;
   localparam logic [7:0] BYTE_CAP = 8'd255;

   typedef struct packed {
      logic [2:0] fault_flags;
      logic filter_inhibit;
      logic [15:0] sensor1_raw_pos;
      logic [15:0] sensor1_filt_pos;
      logic [15:0] sensor2_raw_pos;
      logic [15:0] sensor2_filt_pos;
      logic [15:0] sensor1_closed;
      logic [15:0] sensor1_open;
      logic [15:0] sensor2_closed;
      logic [15:0] sensor2_open;
      logic [15:0] sensor1_limp;
      logic [15:0] sensor2_limp;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] mode;
      logic mode_changed;
      logic [10:0] selected_pos;
      logic [7:0] pos_byte;
      logic [10:0] closed_stop;
      logic [10:0] open_stop;
      logic [10:0] limp_offset;
   } rsp_payload_type;

   // configured defaults used in failure mode
   typedef struct packed {
      logic [15:0] position;
      logic [15:0] closed_stop;
      logic [15:0] open_stop;
      logic [15:0] limp_home;
   } defaults_type;

   // mode and latched stops from the mode unit
   typedef struct packed {
      logic [1:0] mode;
      logic mode_changed;
      logic [10:0] closed_stop;
      logic [10:0] open_stop;
      logic [10:0] limp_offset;
   } mode_status_type;

   // saturate a 16-bit position to 1024
   function automatic logic [10:0] cap_pos(input logic [15:0] v);
      logic [10:0] r;
      if (v > {5'd0, POS_CAP}) begin
         r = POS_CAP;
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

endpackage

// File: sv/dssms_mode.sv
// mode update and stop relatch for the dual sensor safety mode selector
// holds the mode, refresh and latched stop registers
// depends on dssms_pkg
module dssms_mode import dssms_pkg::*; (
   input logic clock,
   input logic reset,
   input logic advance,
   input req_payload_type item,
   input defaults_type dflt,
   output mode_status_type status
);

   logic [1:0] mode_ff, mode_in;
   logic refresh_ff;
   logic [10:0] closed_ff, open_ff, limp_ff;
   logic relatch;
   logic [15:0] closed_src, open_src, limp_src;
   logic [10:0] closed_new, open_new, limp_new;

   // next mode from the fault flags; failure is sticky while any flag stays
   always_comb begin
      if (item.fault_flags[FLAG_BOTH] ||
          (item.fault_flags[FLAG_S1] && item.fault_flags[FLAG_S2])) begin
         mode_in = MODE_FAIL;
      end else if (item.fault_flags[FLAG_S2]) begin
         mode_in = (mode_ff != MODE_FAIL) ? MODE_S1_ONLY : MODE_FAIL;
      end else if (item.fault_flags[FLAG_S1]) begin
         mode_in = (mode_ff != MODE_FAIL) ? MODE_S2_ONLY : MODE_FAIL;
      end else begin
         mode_in = MODE_NORMAL;
      end
   end

   assign relatch = (mode_in != mode_ff) || refresh_ff;

   // stop source by new mode
   always_comb begin
      case (mode_in)
         MODE_NORMAL, MODE_S1_ONLY: begin
            closed_src = item.sensor1_closed;
            open_src = item.sensor1_open;
            limp_src = item.sensor1_limp;
         end
         MODE_S2_ONLY: begin
            closed_src = item.sensor2_closed;
            open_src = item.sensor2_open;
            limp_src = item.sensor2_limp;
         end
         default: begin
            closed_src = dflt.closed_stop;
            open_src = dflt.open_stop;
            limp_src = dflt.limp_home;
         end
      endcase
   end

   // capped stops and clamped limp offset from the new closed stop
   always_comb begin
      closed_new = cap_pos(closed_src);
      open_new = cap_pos(open_src);
      if (limp_src <= {5'd0, closed_new}) begin
         limp_new = 11'd0;
      end else begin
         limp_new = cap_pos(limp_src - {5'd0, closed_new});
      end
   end

   // state registers, updated once per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         refresh_ff <= 1'b1;
         closed_ff <= 11'd0;
         open_ff <= 11'd0;
         limp_ff <= 11'd0;
      end else if (advance) begin
         mode_ff <= mode_in;
         refresh_ff <= 1'b0;
         if (relatch) begin
            closed_ff <= closed_new;
            open_ff <= open_new;
            limp_ff <= limp_new;
         end
      end
   end

   assign status.mode = mode_in;
   assign status.mode_changed = relatch;
   assign status.closed_stop = relatch ? closed_new : closed_ff;
   assign status.open_stop = relatch ? open_new : open_ff;
   assign status.limp_offset = relatch ? limp_new : limp_ff;

endmodule

// File: sv/dssms_pos.sv
// position select, cap and byte rounding for the safety mode selector
// purely combinational, driven by the new mode
// depends on dssms_pkg
module dssms_pos import dssms_pkg::*; (
   input logic [1:0] mode,
   input req_payload_type item,
   input logic [15:0] default_position,
   output logic [10:0] selected_pos,
   output logic [7:0] pos_byte
);

   logic [15:0] s1_pos, s2_pos, src;
   logic [11:0] rounded;

   assign s1_pos = item.filter_inhibit ? item.sensor1_raw_pos : item.sensor1_filt_pos;
   assign s2_pos = item.filter_inhibit ? item.sensor2_raw_pos : item.sensor2_filt_pos;

   // source by mode
   always_comb begin
      case (mode)
         MODE_NORMAL, MODE_S1_ONLY: src = s1_pos;
         MODE_S2_ONLY: src = s2_pos;
         default: src = default_position;
      endcase
   end

   // cap, then round to quarter steps and saturate to a byte
   always_comb begin
      selected_pos = cap_pos(src);
      rounded = ({1'b0, selected_pos} + 12'd2) >> 2;
      if (rounded > {4'd0, BYTE_CAP}) begin
         pos_byte = BYTE_CAP;
      end else begin
         pos_byte = rounded[7:0];
      end
   end

endmodule

// File: sv/dual_sensor_safety_mode_selector.sv
// Dual sensor throttle safety mode selector. Each request transaction carries fault
// flags, both sensors' positions and learned stops; each one yields exactly one
// response transaction with the updated mode, the selected position (capped at
// 1024), its rounded byte form and the latched closed/open stops and limp offset,
// which are relatched on a mode change and on the first transaction after reset.
// The block is a two-register pipeline: an input register and a result register
// with short logic between them, so it takes one transaction per cycle while the
// response side does not stall. The user must write the default registers through
// the csr port (always ready) only while idle; the block does not enforce this.
// Depends on dssms_pkg, dssms_mode and dssms_pos.
module dual_sensor_safety_mode_selector import dssms_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input req_payload_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output rsp_payload_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [15:0] csr_data
);

   logic s1_vld_ff;
   req_payload_type s1_data_ff;
   logic rsp_vld_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   defaults_type dflt_ff;
   logic advance;
   mode_status_type status;
   logic [10:0] selected_pos;
   logic [7:0] pos_byte;

   // handshake: stage one moves on when the result register is free or drains
   assign advance = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = s1_vld_ff && !advance;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dflt_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEFAULT_POSITION: dflt_ff.position <= csr_data;
            CSR_DEFAULT_CLOSED_STOP: dflt_ff.closed_stop <= csr_data;
            CSR_DEFAULT_OPEN_STOP: dflt_ff.open_stop <= csr_data;
            CSR_DEFAULT_LIMP_HOME: dflt_ff.limp_home <= csr_data;
            default: dflt_ff <= dflt_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_data_ff <= req_payload;
      end
   end

   dssms_mode u_mode (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .item(s1_data_ff),
      .dflt(dflt_ff),
      .status(status)
   );

   dssms_pos u_pos (
      .mode(status.mode),
      .item(s1_data_ff),
      .default_position(dflt_ff.position),
      .selected_pos(selected_pos),
      .pos_byte(pos_byte)
   );

   // result assembly
   always_comb begin
      rsp_data_in.mode = status.mode;
      rsp_data_in.mode_changed = status.mode_changed;
      rsp_data_in.selected_pos = selected_pos;
      rsp_data_in.pos_byte = pos_byte;
      rsp_data_in.closed_stop = status.closed_stop;
      rsp_data_in.open_stop = status.open_stop;
      rsp_data_in.limp_offset = status.limp_offset;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_payload = rsp_data_ff;

   // failure is left only when every fault flag is clear
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_data_in.mode == MODE_FAIL && s1_data_ff.fault_flags != 3'd0)
      |=> (advance || $past(advance)) && rsp_payload.mode == MODE_FAIL)
      else $error("failure mode left with a fault flag set");

   // a changed mode always reports a relatch
   a_relatch_on_change: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_vld_ff && !rsp_stall && rsp_data_in.mode != rsp_payload.mode)
      |-> rsp_data_in.mode_changed)
      else $error("mode change without relatch");

   // selected position, closed stop and limp offset stay within the cap
   a_caps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.selected_pos <= POS_CAP &&
                     rsp_payload.closed_stop <= POS_CAP &&
                     rsp_payload.limp_offset <= POS_CAP))
      else $error("position value above cap");

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// testbench for the dual sensor safety mode selector: directed and random ticks
// checked against a scoreboard that tracks mode, latched stops and default registers
// depends on dssms_pkg and dual_sensor_safety_mode_selector
module tb import dssms_pkg::*; ();

   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_OFF_CYCLES = 48;
   localparam int HOLD_OFF_TICKS = 24;
   localparam int TICKS_PER_PHASE = 200;

   localparam logic [2:0] FLAGS_NONE = 3'b000;
   localparam logic [2:0] FLAGS_BOTH = 3'b001 << FLAG_BOTH;
   localparam logic [2:0] FLAGS_S1 = 3'b001 << FLAG_S1;
   localparam logic [2:0] FLAGS_S2 = 3'b001 << FLAG_S2;
   localparam logic [2:0] FLAGS_ALL = 3'b111;

   // expected responses and the state that produces them
   class mode_scoreboard;
      rsp_payload_type expected_q[$];
      logic [15:0] dflt_position = '0;
      logic [15:0] dflt_closed = '0;
      logic [15:0] dflt_open = '0;
      logic [15:0] dflt_limp = '0;
      logic [1:0] mode_now = MODE_NORMAL;
      bit first_tick = 1'b1;
      logic [10:0] closed_latch = '0;
      logic [10:0] open_latch = '0;
      logic [10:0] limp_latch = '0;
      int error_count = 0;
      int checked_count = 0;
      int relatch_count = 0;
      int mode_seen[4] = '{0, 0, 0, 0};

      function int pending();
         return expected_q.size();
      endfunction

      function void set_default(logic [1:0] idx, logic [15:0] value);
         case (idx)
            CSR_DEFAULT_POSITION: dflt_position = value;
            CSR_DEFAULT_CLOSED_STOP: dflt_closed = value;
            CSR_DEFAULT_OPEN_STOP: dflt_open = value;
            default: dflt_limp = value;
         endcase
      endfunction

      // saturate a position to full travel
      function logic [10:0] clip_to_travel(logic [15:0] v);
         return (v > 16'(POS_CAP)) ? POS_CAP : v[10:0];
      endfunction

      // sensor 1 serves normal and sensor1-only, the defaults serve failure
      function logic [15:0] from_source(logic [1:0] m, logic [15:0] s1, logic [15:0] s2,
                                        logic [15:0] dflt);
         case (m)
            MODE_NORMAL, MODE_S1_ONLY: return s1;
            MODE_S2_ONLY: return s2;
            default: return dflt;
         endcase
      endfunction

      function void note_request(req_payload_type r);
         logic [1:0] next_mode;
         bit relatch;
         logic [15:0] limp_src;
         logic [15:0] pos_s1;
         logic [15:0] pos_s2;
         int rounded;
         rsp_payload_type e;
         // mode update, failure is sticky until every flag clears
         if (r.fault_flags[FLAG_BOTH] || (r.fault_flags[FLAG_S1] && r.fault_flags[FLAG_S2])) begin
            next_mode = MODE_FAIL;
         end else if (r.fault_flags[FLAG_S2]) begin
            next_mode = (mode_now != MODE_FAIL) ? MODE_S1_ONLY : MODE_FAIL;
         end else if (r.fault_flags[FLAG_S1]) begin
            next_mode = (mode_now != MODE_FAIL) ? MODE_S2_ONLY : MODE_FAIL;
         end else begin
            next_mode = MODE_NORMAL;
         end
         relatch = (next_mode != mode_now) || first_tick;
         mode_now = next_mode;
         first_tick = 1'b0;
         // relatch stops from the new mode's source
         if (relatch) begin
            closed_latch = clip_to_travel(from_source(next_mode, r.sensor1_closed,
                                                      r.sensor2_closed, dflt_closed));
            open_latch = clip_to_travel(from_source(next_mode, r.sensor1_open,
                                                    r.sensor2_open, dflt_open));
            limp_src = from_source(next_mode, r.sensor1_limp, r.sensor2_limp, dflt_limp);
            if (limp_src <= 16'(closed_latch)) begin
               limp_latch = '0;
            end else begin
               limp_latch = clip_to_travel(limp_src - 16'(closed_latch));
            end
            relatch_count++;
         end
         // position and its byte form
         pos_s1 = r.filter_inhibit ? r.sensor1_raw_pos : r.sensor1_filt_pos;
         pos_s2 = r.filter_inhibit ? r.sensor2_raw_pos : r.sensor2_filt_pos;
         e.selected_pos = clip_to_travel(from_source(next_mode, pos_s1, pos_s2, dflt_position));
         rounded = (int'(e.selected_pos) + 2) / 4;
         e.pos_byte = (rounded > 255) ? 8'd255 : rounded[7:0];
         e.mode = next_mode;
         e.mode_changed = relatch;
         e.closed_stop = closed_latch;
         e.open_stop = open_latch;
         e.limp_offset = limp_latch;
         mode_seen[next_mode]++;
         expected_q.push_back(e);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            error_count++;
         end
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_q.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("mode", 16'(want.mode), 16'(got.mode));
         compare_field("mode_changed", 16'(want.mode_changed), 16'(got.mode_changed));
         compare_field("selected_pos", 16'(want.selected_pos), 16'(got.selected_pos));
         compare_field("pos_byte", 16'(want.pos_byte), 16'(got.pos_byte));
         compare_field("closed_stop", 16'(want.closed_stop), 16'(got.closed_stop));
         compare_field("open_stop", 16'(want.open_stop), 16'(got.open_stop));
         compare_field("limp_offset", 16'(want.limp_offset), 16'(got.limp_offset));
         checked_count++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_DEFAULT_POSITION;
   logic [15:0] csr_data = '0;

   mode_scoreboard sb = new();
   int cycle_count = 0;
   int hold_request = 0;
   int hold_offs = 0;
   int default_sets = 0;

   dual_sensor_safety_mode_selector dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // monitor both channels at the rising edge, requests first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_payload);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response(rsp_payload);
         end
      end
   end

   // response side stall pattern, with long hold-offs on request
   int stall_style = 0;
   int stall_left = 0;
   int hold_left = 0;
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
         hold_offs++;
      end
      if (stall_left == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 150);
      end
      stall_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_style)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2: rsp_stall <= ($urandom_range(0, 9) < 7);
            default: rsp_stall <= ((cycle_count % 5) < 2);
         endcase
      end
   end

   function automatic logic [15:0] random_position();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2, 3: return 16'($urandom_range(0, 1100));
         4: return 16'($urandom_range(1018, 1030));
         5, 6: return 16'($urandom);
         default: return 16'($urandom_range(0, 1024));
      endcase
   endfunction

   function automatic logic [2:0] random_flags();
      if ($urandom_range(0, 2) == 0) begin
         return FLAGS_NONE;
      end
      return 3'($urandom_range(1, 7));
   endfunction

   function automatic req_payload_type random_tick();
      req_payload_type r;
      r.fault_flags = random_flags();
      r.filter_inhibit = 1'($urandom_range(0, 1));
      r.sensor1_raw_pos = random_position();
      r.sensor1_filt_pos = random_position();
      r.sensor2_raw_pos = random_position();
      r.sensor2_filt_pos = random_position();
      r.sensor1_closed = random_position();
      r.sensor1_open = random_position();
      r.sensor2_closed = random_position();
      r.sensor2_open = random_position();
      r.sensor1_limp = random_position();
      r.sensor2_limp = random_position();
      // limp just above closed is the interesting side of the offset clamp
      if ($urandom_range(0, 3) == 0) begin
         r.sensor1_limp = r.sensor1_closed + 16'($urandom_range(0, 1100));
      end
      if ($urandom_range(0, 3) == 0) begin
         r.sensor2_limp = r.sensor2_closed + 16'($urandom_range(0, 1100));
      end
      return r;
   endfunction

   // offer one transaction and hold it until accepted
   task automatic send_tick(input req_payload_type p);
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // stop sending and wait for every outstanding response
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_default(input logic [1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_default(idx, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_defaults(input logic [15:0] position, input logic [15:0] closed,
                                input logic [15:0] open, input logic [15:0] limp);
      wait_idle();
      write_default(CSR_DEFAULT_POSITION, position);
      write_default(CSR_DEFAULT_CLOSED_STOP, closed);
      write_default(CSR_DEFAULT_OPEN_STOP, open);
      write_default(CSR_DEFAULT_LIMP_HOME, limp);
      default_sets++;
   endtask

   task automatic directed_ticks();
      req_payload_type r;
      // first tick after reset relatches, then saturation at all ones
      r = '0;
      send_tick(r);
      r = '1;
      r.fault_flags = FLAGS_NONE;
      send_tick(r);
      // byte rounding around zero and near the top
      r = random_tick();
      r.fault_flags = FLAGS_NONE;
      r.filter_inhibit = 1'b0;
      r.sensor1_filt_pos = 16'd1;
      send_tick(r);
      r.filter_inhibit = 1'b1;
      r.sensor1_raw_pos = 16'd2;
      send_tick(r);
      r.sensor1_raw_pos = 16'd1017;
      send_tick(r);
      r.sensor1_raw_pos = 16'd1018;
      send_tick(r);
      // sensor2 fault: closed above cap, limp above the capped closed
      r.fault_flags = FLAGS_S2;
      r.sensor1_closed = 16'd2000;
      r.sensor1_open = 16'd1500;
      r.sensor1_limp = 16'd1500;
      send_tick(r);
      send_tick(r);
      // sensor1 fault: limp below closed clamps to zero
      r.fault_flags = FLAGS_S1;
      r.sensor2_closed = 16'd500;
      r.sensor2_limp = 16'd100;
      r.filter_inhibit = 1'b0;
      send_tick(r);
      r.filter_inhibit = 1'b1;
      send_tick(r);
      // failure from defaults, sticky under single flags
      r.fault_flags = FLAGS_BOTH;
      send_tick(r);
      r.fault_flags = FLAGS_S1;
      send_tick(r);
      r.fault_flags = FLAGS_S2;
      send_tick(r);
      r.fault_flags = FLAGS_S1 | FLAGS_S2;
      send_tick(r);
      // leave failure with a huge limp offset
      r.fault_flags = FLAGS_NONE;
      r.sensor1_closed = 16'd0;
      r.sensor1_limp = 16'hFFFF;
      send_tick(r);
      r.fault_flags = FLAGS_S1 | FLAGS_S2;
      send_tick(r);
      r.fault_flags = FLAGS_ALL;
      send_tick(r);
      // limp equal to closed, then one above the cap
      r.fault_flags = FLAGS_NONE;
      r.sensor1_closed = 16'd1024;
      r.sensor1_limp = 16'd1024;
      send_tick(r);
      r.fault_flags = FLAGS_S2;
      r.sensor1_closed = 16'd1025;
      r.sensor1_limp = 16'd1025;
      send_tick(r);
      r.fault_flags = FLAGS_BOTH;
      send_tick(r);
      r.fault_flags = FLAGS_NONE;
      send_tick(r);
      // single sensor modes swap directly
      r.fault_flags = FLAGS_S1;
      r.sensor2_closed = 16'hFFFF;
      r.sensor2_open = 16'hFFFF;
      r.sensor2_limp = 16'd0;
      send_tick(r);
      r.fault_flags = FLAGS_S2;
      send_tick(r);
   endtask

   // bursts of random ticks; flag patterns are held for a few ticks so modes settle
   task automatic random_ticks(input int count);
      req_payload_type r;
      logic [2:0] held_flags;
      int held_left;
      int items_left;
      int burst;
      bit paused;
      held_flags = FLAGS_NONE;
      held_left = 0;
      items_left = count;
      paused = 1'b0;
      // long output hold-off while input keeps coming
      hold_request = HOLD_OFF_CYCLES;
      for (int i = 0; i < HOLD_OFF_TICKS; i++) begin
         send_tick(random_tick());
      end
      items_left -= HOLD_OFF_TICKS;
      while (items_left > 0) begin
         burst = $urandom_range(1, 24);
         if (burst > items_left) begin
            burst = items_left;
         end
         for (int i = 0; i < burst; i++) begin
            if (held_left == 0) begin
               held_flags = random_flags();
               held_left = $urandom_range(1, 8);
            end
            held_left--;
            r = random_tick();
            if ($urandom_range(0, 9) != 0) begin
               r.fault_flags = held_flags;
            end
            send_tick(r);
         end
         items_left -= burst;
         if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 8));
         end
         // pause mid-phase until every response is back
         if (!paused && items_left <= count / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_defaults(16'd600, 16'd200, 16'd900, 16'd1500);
      directed_ticks();

      load_defaults(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      random_ticks(TICKS_PER_PHASE);
      load_defaults(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_ticks(TICKS_PER_PHASE);
      load_defaults(16'd1023, 16'd1024, 16'd1025, 16'd1025);
      random_ticks(TICKS_PER_PHASE);
      load_defaults(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      random_ticks(TICKS_PER_PHASE);

      wait_idle();
      if (sb.pending() != 0) begin
         $error("%0d expected responses never arrived", sb.pending());
      end
      $display("tb: %0d ticks checked, %0d relatches, modes normal/s1/s2/fail %0d/%0d/%0d/%0d",
               sb.checked_count, sb.relatch_count, sb.mode_seen[MODE_NORMAL],
               sb.mode_seen[MODE_S1_ONLY], sb.mode_seen[MODE_S2_ONLY], sb.mode_seen[MODE_FAIL]);
      $display("tb: %0d default register sets, %0d long output hold-offs",
               default_sets, hold_offs);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
